>>> hw/rtl/htfsc_pkg.sv
// shared constants, codes and control structs of the frame sum checker
package htfsc_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = $clog2(STORE_DEPTH * 255 + 1);
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD      = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HEAD = 1'd0;
    localparam t_cfg_idx CFG_END  = 1'd1;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] END_RESET  = 8'd85;

    // controller to datapath
    typedef struct packed {
        logic    clear;       // drop the open frame
        logic    store;       // write the request byte into the frame store
        logic    emit_start;  // rewind the read index
        logic    idx_inc;     // step the read index
        logic    load_err;    // load an error result
        t_status err_code;
        logic    load_data;   // load the store byte at the read index
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_head;
        logic is_end;
        logic full;
        logic empty;
        logic one;
        logic match;
        logic idx_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hw/rtl/htfsc_ram.sv
// generic single write port ram with registered read
module htfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/htfsc_dp.sv
// datapath: config bytes, frame count and sum, frame store, output register
module htfsc_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  htfsc_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [htfsc_pkg::BYTE_W-1:0]          i_cfg_data,
    input  logic [htfsc_pkg::BYTE_W-1:0]          i_rx_byte,
    input  htfsc_pkg::t_dp_cmd                    i_cmd,
    output htfsc_pkg::t_dp_sts                    o_sts,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [htfsc_pkg::BYTE_W-1:0]          o_out_data,
    output htfsc_pkg::t_status                    o_out_status,
    output logic                                  o_out_last
);

    logic [htfsc_pkg::BYTE_W-1:0]   r_head;
    logic [htfsc_pkg::BYTE_W-1:0]   r_end;
    logic [htfsc_pkg::CNT_W-1:0]    r_count;
    logic [htfsc_pkg::SUM_W-1:0]    r_sum;
    logic [htfsc_pkg::BYTE_W-1:0]   r_last_byte;
    logic [htfsc_pkg::STORE_AW-1:0] r_idx;
    logic                           r_out_valid;
    logic [htfsc_pkg::BYTE_W-1:0]   r_out_data;
    htfsc_pkg::t_status             r_out_status;
    logic                           r_out_last;
    logic [htfsc_pkg::BYTE_W-1:0]   w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= htfsc_pkg::HEAD_RESET;
            r_end  <= htfsc_pkg::END_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                htfsc_pkg::CFG_HEAD: r_head <= i_cfg_data;
                htfsc_pkg::CFG_END:  r_end  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.store) begin
            r_count <= r_count + htfsc_pkg::CNT_W'(1);
            r_sum   <= r_sum + htfsc_pkg::SUM_W'(i_rx_byte);
        end
    end

    // newest stored byte is the checksum candidate
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_last_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.emit_start) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + htfsc_pkg::STORE_AW'(1);
        end
    end

    htfsc_ram #(
        .WIDTH (htfsc_pkg::BYTE_W),
        .DEPTH (htfsc_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_count[htfsc_pkg::STORE_AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_err || i_cmd.load_data) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_data   <= '0;
            r_out_status <= i_cmd.err_code;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load_data) begin
            r_out_data   <= w_rdata;
            r_out_status <= htfsc_pkg::ST_OK;
            r_out_last   <= o_sts.idx_last;
        end
    end

    always_comb begin
        o_sts.is_head  = (i_rx_byte == r_head);
        o_sts.is_end   = (i_rx_byte == r_end);
        o_sts.full     = (r_count == htfsc_pkg::CNT_W'(htfsc_pkg::STORE_DEPTH));
        o_sts.empty    = (r_count == '0);
        o_sts.one      = (r_count == htfsc_pkg::CNT_W'(1));
        // payload sum equals checksum <=> total sum equals twice the checksum
        o_sts.match    = (r_sum == htfsc_pkg::SUM_W'({r_last_byte, 1'b0}));
        o_sts.idx_last = ((htfsc_pkg::CNT_W'(r_idx) + htfsc_pkg::CNT_W'(2)) == r_count);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

>>> hw/rtl/htfsc_ctrl.sv
// controller: hunt, collect and payload release sequencing
module htfsc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  htfsc_pkg::t_dp_sts i_sts,
    output htfsc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_HUNT,
        S_FRAME,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready = ((r_state == S_HUNT) || (r_state == S_FRAME)) && i_sts.out_free;
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.err_code = htfsc_pkg::ST_BAD;
        case (r_state)
            S_HUNT: begin
                if (w_acc && i_sts.is_head) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_FRAME;
                end
            end
            S_FRAME: begin
                if (w_acc) begin
                    if (!i_sts.is_end) begin
                        if (i_sts.full) begin
                            o_cmd.clear    = 1'b1;
                            o_cmd.load_err = 1'b1;
                            o_cmd.err_code = htfsc_pkg::ST_OVERFLOW;
                            n_state        = S_HUNT;
                        end else begin
                            o_cmd.store = 1'b1;
                        end
                    end else if (i_sts.empty || !i_sts.match) begin
                        o_cmd.clear    = 1'b1;
                        o_cmd.load_err = 1'b1;
                        n_state        = S_HUNT;
                    end else if (i_sts.one) begin
                        // checksum only, zero sum matched: nothing to release
                        o_cmd.clear = 1'b1;
                        n_state     = S_HUNT;
                    end else begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_data = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_HUNT;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/head_tail_frame_sum_checker_unit.sv
// top level of the head/tail byte frame deframer with additive checksum check
//
// channel   dir  handshake              payload
// s (rx)    in   i_s_tvalid/o_s_tready  i_s_tdata[7:0] rx_byte
// m (res)   out  o_m_tvalid/i_m_tready  o_m_tdata[7:0] payload_byte, o_m_tuser[1:0] status,
//                                       o_m_tlast last
// cfg       in   i_cfg_we               i_cfg_idx (0 head_byte, 1 end_byte), i_cfg_data[7:0]
//
// a received byte is handled as it is accepted: hunting, storing, and error results are decided in the
// request cycle and the error result goes straight to the output register
// a good frame releases its payload byte by byte, each byte passing the S_READ and S_LOAD states
// for the registered read port of the frame store; S_LOAD also waits out any output stall
// synchronous active-low reset returns to hunting; the frame store is not cleared
// the rx side stalls while a payload is released or the output register is held by a stall
module head_tail_frame_sum_checker_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // rx bytes
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [htfsc_pkg::BYTE_W-1:0] i_s_tdata,   // [7:0] rx_byte
    // results
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [htfsc_pkg::BYTE_W-1:0] o_m_tdata,   // [7:0] payload_byte
    output logic [1:0]                   o_m_tuser,   // [1:0] status
    output logic                         o_m_tlast,
    // register writes
    input  logic                         i_cfg_we,
    input  htfsc_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [htfsc_pkg::BYTE_W-1:0] i_cfg_data
);

    htfsc_pkg::t_dp_cmd w_cmd;
    htfsc_pkg::t_dp_sts w_sts;
    htfsc_pkg::t_status w_status;

    // sequencing of hunt, collect and release
    htfsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // count, sum, frame store and the output register
    htfsc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_rx_byte    (i_s_tdata),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_data   (o_m_tdata),
        .o_out_status (w_status),
        .o_out_last   (o_m_tlast)
    );

    assign o_m_tuser = w_status;

    // no status code beyond overflow ever leaves the block
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= htfsc_pkg::ST_OVERFLOW))
        else $error("status code out of range");

    // error results carry a zero byte and close their request
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != htfsc_pkg::ST_OK)) |-> ((o_m_tdata == '0) && o_m_tlast))
        else $error("malformed error result");

    // a held result blocks new rx requests
    a_stall_blocks_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("rx accepted while result stalled");

endmodule

>>> dv/testbench.sv
// self-checking testbench for the head/tail frame sum checker unit
module testbench;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 100;   // settle time after the last expected result
    localparam int HOLD_CYCLES     = 600;
    localparam int ITEMS_PER_PHASE = 55;

    typedef struct packed {
        logic [htfsc_pkg::BYTE_W-1:0] data;
        htfsc_pkg::t_status           status;
        logic                         last;
    } t_frame_result;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [htfsc_pkg::BYTE_W-1:0] i_s_tdata  = '0;
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [htfsc_pkg::BYTE_W-1:0] o_m_tdata;              // [7:0] payload_byte
    logic [1:0]                   o_m_tuser;              // [1:0] status
    logic                         o_m_tlast;
    logic                         i_cfg_we   = 1'b0;
    htfsc_pkg::t_cfg_idx          i_cfg_idx  = htfsc_pkg::CFG_HEAD;
    logic [htfsc_pkg::BYTE_W-1:0] i_cfg_data = '0;

    head_tail_frame_sum_checker_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // mirror of the block state
    logic [htfsc_pkg::BYTE_W-1:0] head_cfg = htfsc_pkg::HEAD_RESET;
    logic [htfsc_pkg::BYTE_W-1:0] end_cfg  = htfsc_pkg::END_RESET;
    logic                         frame_open = 1'b0;
    int                           stored_cnt = 0;
    int                           frame_total = 0;
    logic [htfsc_pkg::BYTE_W-1:0] frame_bytes [htfsc_pkg::STORE_DEPTH];

    t_frame_result     expected_results [$];
    t_frame_result     result_want;
    int                framed_bytes   = 0;   // requests that the block did not ignore
    int                mismatch_cnt   = 0;
    int                cycle_cnt      = 0;
    int                sender_idle_pct = 0;
    int                recv_stall_pct  = 0;
    int                hold_len = 0;
    int                held     = 0;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: long hold-off first if one is pending, else random stalls
    always @(posedge i_clk) begin
        if (held < hold_len) begin
            held       <= held + 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    endtask

    // compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result data=%02h status=%0d last=%0b",
                                        o_m_tdata, o_m_tuser, o_m_tlast));
            end else begin
                result_want = expected_results.pop_front();
                if (o_m_tdata !== result_want.data || o_m_tuser !== result_want.status ||
                    o_m_tlast !== result_want.last)
                    flag_mismatch($sformatf(
                        "expected data=%02h status=%0d last=%0b, got data=%02h status=%0d last=%0b",
                        result_want.data, result_want.status, result_want.last,
                        o_m_tdata, o_m_tuser, o_m_tlast));
            end
        end
    end

    // deframer prediction for one accepted rx byte
    task automatic predict_rx(input logic [htfsc_pkg::BYTE_W-1:0] b);
        int                           pay_len;
        logic [htfsc_pkg::BYTE_W-1:0] chk;
        if (!frame_open) begin
            // hunting: only the head byte matters
            if (b == head_cfg) begin
                frame_open  = 1'b1;
                stored_cnt  = 0;
                frame_total = 0;
                framed_bytes++;
            end
            return;
        end
        framed_bytes++;
        if (b != end_cfg) begin
            if (stored_cnt >= htfsc_pkg::STORE_DEPTH) begin
                // store full: frame dropped, byte lost
                frame_open = 1'b0;
                expected_results.push_back('{8'h00, htfsc_pkg::ST_OVERFLOW, 1'b1});
            end else begin
                frame_bytes[stored_cnt] = b;
                stored_cnt++;
                frame_total += b;
            end
        end else begin
            frame_open = 1'b0;
            if (stored_cnt == 0) begin
                expected_results.push_back('{8'h00, htfsc_pkg::ST_BAD, 1'b1});
            end else begin
                pay_len = stored_cnt - 1;
                chk     = frame_bytes[pay_len];
                // unreduced compare: payload sums above 255 never match
                if (frame_total - chk != chk) begin
                    expected_results.push_back('{8'h00, htfsc_pkg::ST_BAD, 1'b1});
                end else begin
                    for (int i = 0; i < pay_len; i++)
                        expected_results.push_back('{frame_bytes[i], htfsc_pkg::ST_OK,
                                                     i == pay_len - 1});
                end
            end
        end
    endtask

    // offer one byte, with a random gap first, and wait for the request to be taken
    task automatic send_byte(input logic [htfsc_pkg::BYTE_W-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        predict_rx(b);
    endtask

    // stop offering and let every expected result come out
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input htfsc_pkg::t_cfg_idx idx,
                             input logic [htfsc_pkg::BYTE_W-1:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == htfsc_pkg::CFG_HEAD)
            head_cfg = val;
        else
            end_cfg = val;
    endtask

    // random byte that does not close the frame, up to maxv unless maxv is 0 and the end byte is 0
    function automatic logic [htfsc_pkg::BYTE_W-1:0] pick_byte(input int maxv);
        logic [htfsc_pkg::BYTE_W-1:0] v;
        v = htfsc_pkg::BYTE_W'($urandom_range(maxv, 0));
        if (v == end_cfg)
            v = (maxv == 0) ? v + 8'd1 : ((v == 0) ? 8'd1 : v - 8'd1);
        return v;
    endfunction

    // head, payload, checksum, end; good_sum aims for a matching checksum
    task automatic send_frame(input int pay_len, input bit good_sum);
        int                           budget;
        int                           total;
        logic [htfsc_pkg::BYTE_W-1:0] b;
        budget = 255;
        total  = 0;
        send_byte(head_cfg);
        for (int i = 0; i < pay_len; i++) begin
            b = good_sum ? pick_byte(budget) : pick_byte(255);
            budget = (budget > b) ? budget - b : 0;
            total += b;
            send_byte(b);
        end
        send_byte(good_sum ? htfsc_pkg::BYTE_W'(total) : pick_byte(255));
        send_byte(end_cfg);
    endtask

    task automatic send_random_frame();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            // noise while hunting
            repeat ($urandom_range(4, 1)) send_byte(htfsc_pkg::BYTE_W'($urandom_range(255)));
        end else if (r < 14) begin
            send_byte(head_cfg);
            send_byte(end_cfg);
        end else if (r < 17) begin
            send_byte(head_cfg);
            repeat (htfsc_pkg::STORE_DEPTH + 1) send_byte(pick_byte(255));
        end else if (r < 20) begin
            send_frame(0, 1'($urandom_range(1)));
        end else if (r < 38) begin
            send_frame($urandom_range(10, 1), 1'b0);
        end else begin
            // mostly short frames, now and then up to a full store
            send_frame(($urandom_range(9) == 0) ? $urandom_range(htfsc_pkg::STORE_DEPTH - 1)
                                               : $urandom_range(8, 1), 1'b1);
        end
    endtask

    task automatic test_markers_and_sums();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_byte(8'h00);                        // ignored while hunting
        send_byte(8'hFF);
        send_byte(8'hAA); send_byte(8'h55);      // empty frame
        send_byte(8'hAA); send_byte(8'h00); send_byte(8'h55);   // checksum only, zero
        send_byte(8'hAA); send_byte(8'h07); send_byte(8'h55);   // checksum only, nonzero
        // head byte inside the payload is plain data
        send_byte(8'hAA); send_byte(8'h01); send_byte(8'h02); send_byte(8'hAA);
        send_byte(8'hAD); send_byte(8'h55);
        // payload sum of 256 against checksum 0
        send_byte(8'hAA); send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00);
        send_byte(8'h55);
        wait_idle();
    endtask

    task automatic test_overflow();
        send_byte(head_cfg);
        for (int i = 0; i <= htfsc_pkg::STORE_DEPTH; i++)
            send_byte(htfsc_pkg::BYTE_W'(i + 1));
        // next frame right after the abandoned one still works
        send_frame(3, 1'b1);
        wait_idle();
    endtask

    task automatic test_equal_markers();
        write_reg(htfsc_pkg::CFG_HEAD, 8'h5A);
        write_reg(htfsc_pkg::CFG_END, 8'h5A);
        send_byte(8'h5A); send_byte(8'h5A);                    // opens, then closes empty
        send_byte(8'h5A); send_byte(8'h03); send_byte(8'h03); send_byte(8'h5A);
        wait_idle();
    endtask

    task automatic test_output_hold();
        write_reg(htfsc_pkg::CFG_HEAD, htfsc_pkg::HEAD_RESET);
        write_reg(htfsc_pkg::CFG_END, htfsc_pkg::END_RESET);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_len = HOLD_CYCLES;
        // frames keep coming while results back up
        repeat (4) send_frame(12, 1'b1);
        send_frame(5, 1'b0);
        wait_idle();
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [htfsc_pkg::BYTE_W-1:0] head_v,
                             input logic [htfsc_pkg::BYTE_W-1:0] end_v);
        int goal;
        write_reg(htfsc_pkg::CFG_HEAD, head_v);
        write_reg(htfsc_pkg::CFG_END, end_v);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        goal = framed_bytes + ITEMS_PER_PHASE;
        while (framed_bytes < goal)
            send_random_frame();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [htfsc_pkg::BYTE_W-1:0] h;
        logic [htfsc_pkg::BYTE_W-1:0] e;
        h = htfsc_pkg::BYTE_W'($urandom_range(255));
        e = h ^ htfsc_pkg::BYTE_W'($urandom_range(255, 1));
        run_phase(0, 0, 8'h00, 8'hFF);
        run_phase(75, 0, 8'hFF, 8'h00);
        run_phase(0, 75, h, e);
        run_phase(18, 18, htfsc_pkg::HEAD_RESET, htfsc_pkg::END_RESET);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_markers_and_sums();
        test_overflow();
        test_equal_markers();
        test_output_hold();
        test_random_traffic();
        wait_idle();
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/htfsc_pkg.sv
hw/rtl/htfsc_ram.sv
hw/rtl/htfsc_dp.sv
hw/rtl/htfsc_ctrl.sv
hw/rtl/head_tail_frame_sum_checker_unit.sv
dv/testbench.sv
